>>> hdl/bdp_pkg.sv
// Shared types, constants and helper functions of the bounded decimal parser.
`default_nettype none

package bdp_pkg;

  localparam int CHAR_W       = 8;
  localparam int STATUS_W     = 2;
  localparam int VALUE_W      = 21;
  localparam int LIMIT_W      = 4;
  localparam int WHOLE_W      = 4;
  localparam int FRAC_W       = 17;
  localparam int SCALE_DIGITS = 5;

  localparam logic [CHAR_W-1:0] CH_NUL   = 8'd0;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'd43;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'd45;
  localparam logic [CHAR_W-1:0] CH_DOT   = 8'd46;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'd48;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'd57;

  localparam logic [WHOLE_W-1:0] WHOLE_SAT   = 4'd15;
  localparam logic [LIMIT_W-1:0] LIMIT_CAP   = 4'd9;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd2;

  typedef enum logic [2:0] {
    PH_WS,
    PH_INT,
    PH_DOT,
    PH_FRAC,
    PH_FAIL
  } phase_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK,
    ST_INT_BIG,
    ST_BAD_CHAR,
    ST_RANGE
  } status_t;

  // Character slot handed from the input register to the parse core.
  typedef struct packed {
    logic              valid;
    logic [CHAR_W-1:0] char_code;
  } char_slot_t;

  // Finished result handed from the parse core to the output register.
  typedef struct packed {
    logic                      load;
    status_t                   status;
    logic signed [VALUE_W-1:0] scaled_value;
  } result_t;

  // Value of digit d at fraction position pos (0 = first digit), scaled by 1e5.
  function automatic logic [FRAC_W-1:0] frac_place(input logic [2:0] pos,
                                                   input logic [3:0] d);
    logic [FRAC_W-1:0] dx;
    dx = FRAC_W'(d);
    case (pos)
      3'd0:    frac_place = dx * 17'd10000;
      3'd1:    frac_place = dx * 17'd1000;
      3'd2:    frac_place = dx * 17'd100;
      3'd3:    frac_place = dx * 17'd10;
      3'd4:    frac_place = dx;
      default: frac_place = '0;
    endcase
  endfunction

  // Whole units scaled by 1e5.
  function automatic logic [VALUE_W-1:0] whole_scaled(input logic [WHOLE_W-1:0] w);
    whole_scaled = VALUE_W'(w) * 21'd100000;
  endfunction

endpackage

`default_nettype wire

>>> hdl/bdp_char_if.sv
// Input channel interface: one character item per handshake.
`default_nettype none

interface bdp_char_if import bdp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink   (input valid, input char_code, output ready);
endinterface

`default_nettype wire

>>> hdl/bdp_result_if.sv
// Result channel interface: status and scaled value per handshake.
`default_nettype none

interface bdp_result_if import bdp_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [STATUS_W-1:0]       status;
  logic signed [VALUE_W-1:0] scaled_value;

  modport source (output valid, output status, output scaled_value, input ready);
  modport sink   (input valid, input status, input scaled_value, output ready);
endinterface

`default_nettype wire

>>> hdl/bounded_decimal_parser_unit.sv
// Top level of the bounded decimal parser: input register, parse core, output register.
`default_nettype none

// Parses one decimal number string per run, one character item per cycle, and
// returns a single result (status plus value scaled by 100000) when the null
// character arrives. The block sustains one character item every clock cycle;
// the null item is the only one that needs room in the output register, and it
// waits in the input register while an earlier result is still held there.
// After the null item is accepted it sits in the input register, then passes
// through the parse core into the output register, from which the result shows
// on out_ch.
// magnitude_limit (cfg_wdata, reset value 2, values above 9 act as 9) should
// only be written while no string is in progress.

module bounded_decimal_parser_unit import bdp_pkg::*; #(
  parameter int MAX_FRAC_DIGITS = 5  // fractional digits accepted, 1 to 7
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  bdp_char_if.sink                in_ch,
  bdp_result_if.source            out_ch,
  input  wire logic               cfg_we,
  input  wire logic [LIMIT_W-1:0] cfg_wdata
);

  char_slot_t slot;      // character waiting in the input register
  logic       slot_take; // core consumes that character this cycle
  logic       out_free;  // output register can load a result this cycle
  result_t    result;    // finished result from the core

  // Input side: one-deep register, refilled in the cycle it drains.
  bdp_in_reg u_in_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .slot_take (slot_take),
    .slot      (slot)
  );

  // Parse state machine, limit register and final value assembly.
  bdp_parse_core #(
    .MAX_FRAC_DIGITS (MAX_FRAC_DIGITS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .slot      (slot),
    .out_free  (out_free),
    .slot_take (slot_take),
    .result    (result)
  );

  // Result side: holds one result until out_ch.ready.
  bdp_out_reg u_out_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .result   (result),
    .out_free (out_free),
    .out_ch   (out_ch)
  );

endmodule

`default_nettype wire

>>> hdl/bdp_in_reg.sv
// Input register: holds one character until the parse core takes it.
`default_nettype none

module bdp_in_reg import bdp_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  bdp_char_if.sink    in_ch,
  input  wire logic   slot_take,
  output char_slot_t  slot
);

  logic              valid_r, valid_nxt;
  logic [CHAR_W-1:0] char_r, char_nxt;
  logic              accept;

  // Refill in the same cycle the core drains the slot.
  assign in_ch.ready = !valid_r || slot_take;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    char_nxt  = char_r;
    if (accept) begin
      valid_nxt = 1'b1;
      char_nxt  = in_ch.char_code;
    end else if (slot_take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    char_r <= char_nxt;
  end

  assign slot.valid     = valid_r;
  assign slot.char_code = char_r;

endmodule

`default_nettype wire

>>> hdl/bdp_parse_core.sv
// Parse core: per-character state update and final value assembly.
`default_nettype none

module bdp_parse_core import bdp_pkg::*; #(
  parameter int MAX_FRAC_DIGITS = 5
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [LIMIT_W-1:0] cfg_wdata,
  input  wire char_slot_t         slot,
  input  wire logic               out_free,
  output logic                    slot_take,
  output result_t                 result
);

  localparam int FD_W = $clog2(MAX_FRAC_DIGITS + 1);

  phase_t             phase_r, phase_nxt;
  logic               neg_r, neg_nxt;
  logic [WHOLE_W-1:0] whole_r, whole_nxt;
  logic [FRAC_W-1:0]  fsc_r, fsc_nxt;      // leading fraction digits, scaled by 1e5
  logic               fnz_r, fnz_nxt;      // any fraction digit nonzero
  logic [FD_W-1:0]    fdig_r, fdig_nxt;
  status_t            err_r, err_nxt;
  logic [LIMIT_W-1:0] limit_r;

  logic [CHAR_W-1:0]  c;
  logic               is_digit, is_ws, is_nul;
  logic [3:0]         d;
  logic [LIMIT_W-1:0] eff;
  logic [7:0]         wsum;
  logic [VALUE_W-1:0] mag;
  status_t            fin_status;

  assign c        = slot.char_code;
  assign is_nul   = (c == CH_NUL);
  assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
  assign is_ws    = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  assign d        = 4'(c - CH_ZERO);
  assign eff      = (limit_r > LIMIT_CAP) ? LIMIT_CAP : limit_r;
  assign wsum     = {4'b0, whole_r} * 8'd10 + {4'b0, d};

  // Null only moves when the output register can take the result.
  assign slot_take = slot.valid && (!is_nul || out_free);

  // Final status and magnitude from the current state.
  always_comb begin
    fin_status = err_r;
    mag        = '0;
    if (err_r == ST_OK) begin
      unique case (phase_r) inside
        PH_WS, PH_INT: begin
          if (whole_r > eff) fin_status = ST_INT_BIG;
          else               mag = whole_scaled(whole_r);
        end
        PH_DOT: fin_status = ST_BAD_CHAR;
        PH_FRAC: begin
          if ((whole_r >= eff) && fnz_r) fin_status = ST_RANGE;
          else mag = whole_scaled(whole_r) + VALUE_W'(fsc_r);
        end
        default: fin_status = ST_RANGE;
      endcase
    end
    if (fin_status != ST_OK) mag = '0;
  end

  assign result.load         = slot_take && is_nul;
  assign result.status       = fin_status;
  assign result.scaled_value = neg_r ? -$signed(mag) : $signed(mag);

  // Next parse state.
  always_comb begin
    phase_nxt = phase_r;
    neg_nxt   = neg_r;
    whole_nxt = whole_r;
    fsc_nxt   = fsc_r;
    fnz_nxt   = fnz_r;
    fdig_nxt  = fdig_r;
    err_nxt   = err_r;
    if (slot_take) begin
      if (is_nul) begin
        phase_nxt = PH_WS;
        neg_nxt   = 1'b0;
        whole_nxt = '0;
        fsc_nxt   = '0;
        fnz_nxt   = 1'b0;
        fdig_nxt  = '0;
        err_nxt   = ST_OK;
      end else begin
        unique case (phase_r) inside
          PH_WS, PH_INT: begin
            if (phase_r == PH_WS && is_ws) begin
              phase_nxt = PH_WS;
            end else if (phase_r == PH_WS && (c == CH_PLUS || c == CH_MINUS)) begin
              neg_nxt   = (c == CH_MINUS);
              phase_nxt = PH_INT;
            end else if (is_digit) begin
              phase_nxt = PH_INT;
              if (phase_r == PH_WS)      whole_nxt = d;
              else if (wsum > 8'(WHOLE_SAT)) whole_nxt = WHOLE_SAT;
              else                       whole_nxt = wsum[WHOLE_W-1:0];
            end else if (whole_r > eff) begin
              err_nxt   = ST_INT_BIG;
              phase_nxt = PH_FAIL;
            end else if (c == CH_DOT) begin
              phase_nxt = PH_DOT;
            end else begin
              err_nxt   = ST_BAD_CHAR;
              phase_nxt = PH_FAIL;
            end
          end
          PH_DOT: begin
            if (is_digit) begin
              fsc_nxt   = frac_place(3'd0, d);
              fnz_nxt   = (d != 4'd0);
              fdig_nxt  = FD_W'(1);
              phase_nxt = PH_FRAC;
            end else begin
              err_nxt   = ST_BAD_CHAR;
              phase_nxt = PH_FAIL;
            end
          end
          PH_FRAC: begin
            if (is_digit && (fdig_r < FD_W'(MAX_FRAC_DIGITS))) begin
              // digits past the fifth are dropped (truncation)
              if (int'(fdig_r) < SCALE_DIGITS) fsc_nxt = fsc_r + frac_place(3'(fdig_r), d);
              fnz_nxt  = fnz_r || (d != 4'd0);
              fdig_nxt = fdig_r + FD_W'(1);
            end else begin
              err_nxt   = ST_RANGE;
              phase_nxt = PH_FAIL;
            end
          end
          default: phase_nxt = phase_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_WS;
      neg_r   <= 1'b0;
      whole_r <= '0;
      fsc_r   <= '0;
      fnz_r   <= 1'b0;
      fdig_r  <= '0;
      err_r   <= ST_OK;
      limit_r <= LIMIT_RESET;
    end else begin
      phase_r <= phase_nxt;
      neg_r   <= neg_nxt;
      whole_r <= whole_nxt;
      fsc_r   <= fsc_nxt;
      fnz_r   <= fnz_nxt;
      fdig_r  <= fdig_nxt;
      err_r   <= err_nxt;
      if (cfg_we) limit_r <= cfg_wdata;
    end
  end

endmodule

`default_nettype wire

>>> hdl/bdp_out_reg.sv
// Output register: holds one result until the sink takes it.
`default_nettype none

module bdp_out_reg import bdp_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire result_t  result,
  output logic          out_free,
  bdp_result_if.source  out_ch
);

  logic                      valid_r, valid_nxt;
  logic [STATUS_W-1:0]       status_r, status_nxt;
  logic signed [VALUE_W-1:0] value_r, value_nxt;

  assign out_free = !valid_r || out_ch.ready;

  always_comb begin
    valid_nxt  = valid_r;
    status_nxt = status_r;
    value_nxt  = value_r;
    if (result.load) begin
      valid_nxt  = 1'b1;
      status_nxt = result.status;
      value_nxt  = result.scaled_value;
    end else if (out_ch.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    status_r <= status_nxt;
    value_r  <= value_nxt;
  end

  assign out_ch.valid        = valid_r;
  assign out_ch.status       = status_r;
  assign out_ch.scaled_value = value_r;

endmodule

`default_nettype wire

>>> verif/testbench.sv
// Self-checking testbench for the bounded decimal parser unit.
module testbench;
  import bdp_pkg::*;

  localparam int MAX_FRAC      = 5;       // fraction digits the unit is built for
  localparam int N_PHASES      = 9;       // one register setting per phase
  localparam int CHARS_PER_PH  = 200;     // random character items per phase
  localparam int HOLD_PHASE    = 6;       // phase that starts with a long receiver hold-off
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 4;       // settling margin after the last result
  localparam int CYCLE_LIMIT   = 400000;
  localparam int MAX_PRINTS    = 200;

  // Expected outcome of one string.
  typedef struct packed {
    status_t             status;
    logic [VALUE_W-1:0]  value;
  } parse_result_t;

  // Tracks the parse of the current string and the results still owed.
  class number_parse_scoreboard;
    phase_t              phase;
    bit                  negative;
    logic [WHOLE_W-1:0]  whole;
    logic [FRAC_W-1:0]   frac;
    int unsigned         frac_digits;
    status_t             first_error;
    logic [LIMIT_W-1:0]  limit;
    parse_result_t       expected_results[$];
    int                  errors;

    function new();
      limit = LIMIT_RESET;
      errors = 0;
      restart();
    endfunction

    function void restart();
      phase = PH_WS;
      negative = 1'b0;
      whole = '0;
      frac = '0;
      frac_digits = 0;
      first_error = ST_OK;
    endfunction

    function void set_limit(logic [LIMIT_W-1:0] v);
      limit = v;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function int unsigned capped_limit();
      return (limit > LIMIT_CAP) ? LIMIT_CAP : limit;
    endfunction

    function bit is_digit(logic [CHAR_W-1:0] c);
      return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    // Integer part closed by a non-digit: an oversized integer wins over anything else.
    function void end_integer(logic [CHAR_W-1:0] c);
      if (whole > capped_limit()) begin
        first_error = ST_INT_BIG;
        phase = PH_FAIL;
      end else if (c == CH_DOT) begin
        phase = PH_DOT;
      end else begin
        first_error = ST_BAD_CHAR;
        phase = PH_FAIL;
      end
    endfunction

    function void note_char(logic [CHAR_W-1:0] c);
      int unsigned   d, w, lim, f, k;
      int            mag;
      status_t       st;
      parse_result_t r;
      d = c - CH_ZERO;
      lim = capped_limit();
      if (c == CH_NUL) begin
        st = first_error;
        mag = 0;
        if (st == ST_OK) begin
          case (phase)
            PH_WS, PH_INT: begin
              if (whole > lim) st = ST_INT_BIG;
              else mag = whole * 100000;
            end
            PH_DOT: st = ST_BAD_CHAR;
            PH_FRAC: begin
              if (whole >= lim && frac != 0) begin
                st = ST_RANGE;
              end else begin
                f = frac;
                for (k = frac_digits; k < SCALE_DIGITS; k++) f = f * 10;
                for (k = SCALE_DIGITS; k < frac_digits; k++) f = f / 10;
                mag = whole * 100000 + f;
              end
            end
            default: st = ST_RANGE;
          endcase
        end
        if (st != ST_OK) mag = 0;
        if (negative) mag = -mag;
        r.status = st;
        r.value = mag[VALUE_W-1:0];
        expected_results.push_back(r);
        restart();
        return;
      end
      case (phase)
        PH_WS: begin
          if (!(c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))) begin
            if (c == CH_PLUS || c == CH_MINUS) begin
              negative = (c == CH_MINUS);
              phase = PH_INT;
            end else begin
              phase = PH_INT;
              if (is_digit(c)) whole = d[WHOLE_W-1:0];
              else end_integer(c);
            end
          end
        end
        PH_INT: begin
          if (is_digit(c)) begin
            w = whole * 10 + d;
            whole = (w > WHOLE_SAT) ? WHOLE_SAT : w[WHOLE_W-1:0];
          end else begin
            end_integer(c);
          end
        end
        PH_DOT: begin
          if (is_digit(c)) begin
            frac = d[FRAC_W-1:0];
            frac_digits = 1;
            phase = PH_FRAC;
          end else begin
            first_error = ST_BAD_CHAR;
            phase = PH_FAIL;
          end
        end
        PH_FRAC: begin
          if (is_digit(c) && frac_digits < MAX_FRAC) begin
            frac = frac * 10 + d;
            frac_digits++;
          end else begin
            first_error = ST_RANGE;
            phase = PH_FAIL;
          end
        end
        default: ;
      endcase
    endfunction

    task report(string msg);
      if (errors < MAX_PRINTS) $display("mismatch @%0t: %s", $time, msg);
      errors++;
    endtask

    task check_result(logic [STATUS_W-1:0] status, logic [VALUE_W-1:0] value);
      parse_result_t exp;
      if (expected_results.size() == 0) begin
        report($sformatf("unexpected result status %0d value %0d", status,
                         $signed(value)));
        return;
      end
      exp = expected_results.pop_front();
      if (status !== exp.status)
        report($sformatf("status got %0d want %0d", status, exp.status));
      if (value !== exp.value)
        report($sformatf("scaled_value got %0d want %0d", $signed(value),
                         $signed(exp.value)));
    endtask
  endclass

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [LIMIT_W-1:0] cfg_wdata;

  bdp_char_if   in_if ();
  bdp_result_if out_if ();

  bounded_decimal_parser_unit #(
    .MAX_FRAC_DIGITS(MAX_FRAC)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_if),
    .out_ch   (out_if),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  number_parse_scoreboard sb;
  int src_idle_pct;    // chance per cycle that the sender holds back an item
  int sink_idle_pct;   // chance per cycle that the receiver drops ready
  bit hold_req;        // asks the receiver for one long hold-off
  int cycle_count;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Run guard: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("bounded_decimal_parser_unit test failed");
      $finish;
    end
  end

  // Both channels are sampled at the rising edge. Input is noted first, so a
  // result can never be checked ahead of the item that caused it.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_if.valid && in_if.ready) sb.note_char(in_if.char_code);
      if (out_if.valid && out_if.ready)
        sb.check_result(out_if.status, out_if.scaled_value);
    end
  end

  // Receiver: random back-pressure, plus one long hold-off on request so the
  // output register and the input register both fill and in_ch stalls.
  initial begin : result_sink
    int held;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_if.ready <= 1'b0;
        for (held = 0; held < HOLD_CYCLES; held++) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  // Offers one character; starts and ends at a falling edge. valid is left
  // high after the handshake so back-to-back items see no bubble.
  task automatic send_char(input logic [CHAR_W-1:0] c);
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.char_code <= c;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Sends a whole string followed by the terminating null item.
  task automatic send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) send_char(s[i]);
    send_char(CH_NUL);
  endtask

  // Drops valid and waits for every owed result, then lets the pipe settle.
  task automatic drain();
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_limit(input logic [LIMIT_W-1:0] v);
    cfg_wdata <= v;
    cfg_we <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_limit(v);
  endtask

  // Random string, no terminator. Mostly well-formed numbers with random
  // content, some with one corrupted or extra character, the rest noise.
  function automatic string random_number_text();
    string s;
    int    kind, n, c, pos;
    s = "";
    kind = $urandom_range(99);
    if (kind < 20) begin
      n = $urandom_range(5);
      repeat (n) s = $sformatf("%s%c", s, $urandom_range(255, 1));
      return s;
    end
    repeat ($urandom_range(2)) begin
      c = $urandom_range(14, CH_TAB);
      if (c == 14) c = CH_SPACE;
      s = $sformatf("%s%c", s, c);
    end
    case ($urandom_range(3))
      0: s = {s, "+"};
      1: s = {s, "-"};
      default: ;
    endcase
    n = $urandom_range(99);
    n = (n < 10) ? 0 : (n < 80) ? 1 : $urandom_range(3, 2);
    repeat (n) s = $sformatf("%s%0d", s, $urandom_range(9));
    if ($urandom_range(1)) begin
      s = {s, "."};
      n = $urandom_range(99);
      n = (n < 5) ? 0 : (n < 13) ? MAX_FRAC + 1 : $urandom_range(MAX_FRAC, 1);
      repeat (n) s = $sformatf("%s%0d", s, $urandom_range(9));
    end
    if (kind < 40) begin
      c = $urandom_range(255, 1);
      if (s.len() > 0 && $urandom_range(1)) begin
        pos = $urandom_range(s.len() - 1);
        s[pos] = c;
      end else begin
        s = $sformatf("%s%c", s, c);
      end
    end
    return s;
  endfunction

  initial begin : stimulus
    logic [LIMIT_W-1:0] limits [N_PHASES];
    int                 ph, sent, eff;
    string              s;

    limits = '{LIMIT_RESET, 4'd9, 4'd0, 4'd15, 4'd1, 4'd10, 4'd5, 4'd3, 4'd7};
    sb = new();
    cycle_count = 0;
    hold_req = 1'b0;
    src_idle_pct = 37;
    sink_idle_pct = 47;
    in_if.valid = 1'b0;
    in_if.char_code = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    rst_n = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed strings at the reset limit of 2.
    send_text("");          // empty string
    send_text("-");         // sign only
    send_text("-0.0");      // negative zero
    send_text("\t99.");     // saturating integer; its error beats the bad dot
    send_text("\377");      // highest character code
    send_text(".5x");       // trailing character after the fraction
    send_text("2.1");       // fraction pushes past the limit
    send_text(".123456");   // one fraction digit too many

    for (ph = 0; ph < N_PHASES; ph++) begin
      drain();
      if (ph > 0) write_limit(limits[ph]);
      // Sender/receiver idling swaps after three phases, then stops.
      if (ph < 3) begin
        src_idle_pct = 37;
        sink_idle_pct = 47;
      end else if (ph < 6) begin
        src_idle_pct = 47;
        sink_idle_pct = 37;
      end else begin
        src_idle_pct = 0;
        sink_idle_pct = 0;
      end
      if (ph == HOLD_PHASE) hold_req = 1'b1;

      // Both edges of the current limit, signed.
      eff = (limits[ph] > LIMIT_CAP) ? LIMIT_CAP : limits[ph];
      send_text($sformatf("-%0d", eff));
      send_text($sformatf("%0d.00001", eff));

      sent = 0;
      while (sent < CHARS_PER_PH) begin
        s = random_number_text();
        send_text(s);
        sent += s.len() + 1;
      end
    end
    drain();

    if (sb.errors == 0) begin
      $display("bounded_decimal_parser_unit test passed");
    end else begin
      $display("bounded_decimal_parser_unit test failed");
    end
    $finish;
  end

endmodule
